// ===== hdl/lsystem_symbol_rewrite_defines.svh =====
// Assertion macros shared by the rewrite engine RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LSYSTEM_SYMBOL_REWRITE_DEFINES_SVH
`define LSYSTEM_SYMBOL_REWRITE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lsr_pkg.sv =====
// Shared types and constants of the symbol rewrite engine.
// Used by lsr_cell, lsr_rule_mem and lsystem_symbol_rewrite; depends on nothing.
package lsr_pkg;

	localparam int SYM_W     = 7;
	localparam int OP_W      = 3;
	localparam int SLOT_W    = 8;
	localparam int RLEN_W    = 5;
	localparam int STATUS_W  = 2;
	localparam int SLEN_W    = 9;
	localparam int CUR_W     = 8;
	localparam int POS_W     = 16;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;

	typedef enum logic [OP_W-1:0] {
		OP_STEP     = 3'd0,
		OP_RULE_SYM = 3'd1,
		OP_RULE_LEN = 3'd2,
		OP_RESTART  = 3'd3,
		OP_READ     = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUT,
		CELL_INSERT,
		CELL_DELETE,
		CELL_TAP_LOAD,
		CELL_TAP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t             op;
		logic [POS_W-1:0]     pos;
		logic [SYM_W-1:0]     sym;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FETCH,
		S_WRITE,
		S_DONE
	} fsm_t;

endpackage

// ===== hdl/lsr_cell.sv =====
// One string position of the rewrite engine: a symbol and a read tap.
// Depends on lsr_pkg for the broadcast command type.
module lsr_cell #(
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lsr_pkg::cell_cmd_t       cmd,
	input  logic [lsr_pkg::SYM_W-1:0] left_sym,
	input  logic [lsr_pkg::SYM_W-1:0] right_sym,
	input  logic [lsr_pkg::SYM_W-1:0] right_tap,
	output logic [lsr_pkg::SYM_W-1:0] sym,
	output logic [lsr_pkg::SYM_W-1:0] tap
);

	localparam logic [lsr_pkg::POS_W-1:0] MY_POS = lsr_pkg::POS_W'(IDX);

	logic [lsr_pkg::SYM_W-1:0] sym_q;
	logic [lsr_pkg::SYM_W-1:0] tap_q;
	logic                      hit;
	logic                      after;

	assign hit   = (cmd.pos == MY_POS);
	assign after = (MY_POS > cmd.pos);
	assign sym   = sym_q;
	assign tap   = tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= '0;
			tap_q <= '0;
		end else begin
			case (cmd.op)
				lsr_pkg::CELL_PUT: begin
					if (hit) sym_q <= cmd.sym;
				end
				lsr_pkg::CELL_INSERT: begin
					if (hit) sym_q <= cmd.sym;
					else if (after) sym_q <= left_sym;
				end
				lsr_pkg::CELL_DELETE: begin
					if (hit || after) sym_q <= right_sym;
				end
				lsr_pkg::CELL_TAP_LOAD: begin
					tap_q <= hit ? sym_q : '0;
				end
				lsr_pkg::CELL_TAP_SHIFT: begin
					tap_q <= right_tap;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/lsr_rule_mem.sv =====
// Rule symbol memory and rule length memory with a clearing pass after reset.
// Depends on lsr_pkg for the symbol width.
module lsr_rule_mem #(
	parameter int ALPHABET_SIZE = 128,
	parameter int MAX_RULE_LEN  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	output logic                                   busy,
	input  logic                                   sym_we,
	input  logic [$clog2(ALPHABET_SIZE)-1:0]       sym_wid,
	input  logic [((MAX_RULE_LEN > 1) ? $clog2(MAX_RULE_LEN) : 1)-1:0] sym_wslot,
	input  logic [lsr_pkg::SYM_W-1:0]              sym_wdata,
	input  logic [$clog2(ALPHABET_SIZE)-1:0]       sym_rid,
	input  logic [((MAX_RULE_LEN > 1) ? $clog2(MAX_RULE_LEN) : 1)-1:0] sym_rslot,
	output logic [lsr_pkg::SYM_W-1:0]              sym_rdata,
	input  logic                                   len_we,
	input  logic [$clog2(ALPHABET_SIZE)-1:0]       len_wid,
	input  logic [$clog2(MAX_RULE_LEN+1)-1:0]      len_wdata,
	input  logic [$clog2(ALPHABET_SIZE)-1:0]       len_rid,
	output logic [$clog2(MAX_RULE_LEN+1)-1:0]      len_rdata
);

	localparam int AW    = $clog2(ALPHABET_SIZE);
	localparam int RW    = (MAX_RULE_LEN > 1) ? $clog2(MAX_RULE_LEN) : 1;
	localparam int LNW   = $clog2(MAX_RULE_LEN+1);
	localparam int DEPTH = 2**(AW+RW);
	localparam int ROWS  = 2**AW;

	logic [lsr_pkg::SYM_W-1:0] sym_mem [DEPTH];
	logic [LNW-1:0]            len_mem [ROWS];

	logic [AW+RW-1:0]          clr_q;
	logic                      busy_q;
	logic [AW-1:0]             clr_id;
	logic [RW-1:0]             clr_slot;

	logic                      s_we;
	logic [AW+RW-1:0]          s_addr;
	logic [lsr_pkg::SYM_W-1:0] s_data;
	logic                      l_we;
	logic [AW-1:0]             l_addr;
	logic [LNW-1:0]            l_data;

	logic [lsr_pkg::SYM_W-1:0] sym_rdata_q;
	logic [LNW-1:0]            len_rdata_q;

	assign clr_id   = clr_q[AW+RW-1:RW];
	assign clr_slot = clr_q[RW-1:0];
	assign busy      = busy_q;
	assign sym_rdata = sym_rdata_q;
	assign len_rdata = len_rdata_q;

	// While clearing, every rule becomes the identity: position zero holds the
	// rule's own symbol and the length is one.
	always_comb begin
		s_we   = busy_q | sym_we;
		s_addr = busy_q ? clr_q : {sym_wid, sym_wslot};
		s_data = busy_q ? ((clr_slot == '0) ? lsr_pkg::SYM_W'(clr_id) : '0) : sym_wdata;
		l_we   = busy_q ? (clr_slot == '0) : len_we;
		l_addr = busy_q ? clr_id : len_wid;
		l_data = busy_q ? LNW'(1) : len_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == '1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_we) sym_mem[s_addr] <= s_data;
		sym_rdata_q <= sym_mem[{sym_rid, sym_rslot}];
	end

	always_ff @(posedge clk) begin
		if (l_we) len_mem[l_addr] <= l_data;
		len_rdata_q <= len_mem[len_rid];
	end

endmodule

// ===== hdl/lsystem_symbol_rewrite.sv =====
// Channel     | Dir | Signals                        | Content
// s_axis      | in  | s_tvalid s_tready s_tdata s_tuser | one operation item
// m_axis      | out | m_tvalid m_tready m_tdata m_tuser | one result item per operation
// apb         | in  | psel penable pwrite paddr pwdata | seed_symbol register at 0
//
// Rule writes, restart, unknown codes, refused reads and a step on an empty string
// go from S_EXEC straight to S_DONE.
// A read loads the tap at the slot, then the symbol walks the tap chain one cell per cycle.
// In a step the tap chain brings the symbol under the cursor down to cell 0, then one
// rule symbol is inserted per cycle.
// A deleting rule or a step refused as full goes from S_WRITE to S_DONE with no insert.
// After reset the rule memory clearing pass writes all 2**(AW+RW) rule symbol entries
// (2048 at the defaults) and no item is accepted until it ends.
// A stalled result holds in the output register; the next item is accepted and
// executed, but its result waits in S_DONE until the register frees.
// Depends on lsr_pkg, lsr_cell, lsr_rule_mem and the assertion macro header.
`include "lsystem_symbol_rewrite_defines.svh"

module lsystem_symbol_rewrite #(
	parameter int STRING_DEPTH  = 256,
	parameter int ALPHABET_SIZE = 128,
	parameter int MAX_RULE_LEN  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// rule_id[6:0], slot[14:7], symbol[21:15], rule_length[26:22], zero[31:27]
	input  logic [lsr_pkg::S_TDATA_W-1:0]    s_tdata,
	// operation[2:0]
	input  logic [lsr_pkg::OP_W-1:0]         s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// string_length[8:0], cursor[16:9], read_symbol[23:17]
	output logic [lsr_pkg::M_TDATA_W-1:0]    m_tdata,
	// status[1:0]
	output logic [lsr_pkg::STATUS_W-1:0]     m_tuser,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [2:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int AW  = $clog2(ALPHABET_SIZE);
	localparam int RW  = (MAX_RULE_LEN > 1) ? $clog2(MAX_RULE_LEN) : 1;
	localparam int LNW = $clog2(MAX_RULE_LEN+1);
	localparam int LW  = $clog2(STRING_DEPTH+1);
	localparam int CW  = $clog2(STRING_DEPTH);
	localparam int SW  = ((LW > LNW) ? LW : LNW) + 1;
	localparam int SYM_W = lsr_pkg::SYM_W;

	lsr_pkg::fsm_t state_q, state_d;

	logic [lsr_pkg::OP_W-1:0]   op_q;
	logic [SYM_W-1:0]           rid_q;
	logic [lsr_pkg::SLOT_W-1:0] slot_q;
	logic [SYM_W-1:0]           symin_q;
	logic [lsr_pkg::RLEN_W-1:0] len_q;
	logic [SYM_W-1:0]           seed_q;

	logic [LW-1:0]  count_q, count_d;
	logic [CW-1:0]  cursor_q, cursor_d;
	logic [CW-1:0]  scan_q, scan_d;
	logic [LNW-1:0] wk_q, wk_d;
	logic [SYM_W-1:0] csym_q, csym_d;
	logic [SYM_W-1:0] rdsym_q, rdsym_d;
	lsr_pkg::status_t status_q, status_d;

	logic                              m_tvalid_q;
	logic [lsr_pkg::M_TDATA_W-1:0]     m_tdata_q;
	logic [lsr_pkg::STATUS_W-1:0]      m_tuser_q;

	logic accept;
	logic load_out;
	logic cfg_wr;

	lsr_pkg::cell_cmd_t cmd;
	logic [SYM_W-1:0]   sym_w [STRING_DEPTH];
	logic [SYM_W-1:0]   tap_w [STRING_DEPTH];

	logic             mem_busy;
	logic             sym_we;
	logic             len_we;
	logic [RW-1:0]    rslot;
	logic [SYM_W-1:0] rule_sym;
	logic [LNW-1:0]   rule_len;
	logic [LNW-1:0]   wk_plus;

	logic             in_alpha;
	logic [LNW-1:0]   rep;
	logic [SYM_W-1:0] rsym;
	logic [SW-1:0]    new_count;
	logic [SW-1:0]    cur_rep;
	logic             rid_ok;
	logic             slot_ok;
	logic             len_ok;

	// ---------------------------------------------------------------- cells
	for (genvar i = 0; i < STRING_DEPTH; i++) begin : g_cell
		logic [SYM_W-1:0] left_s;
		logic [SYM_W-1:0] right_s;
		logic [SYM_W-1:0] right_t;
		if (i == 0) begin : g_first
			assign left_s = '0;
		end else begin : g_mid_l
			assign left_s = sym_w[i-1];
		end
		if (i == STRING_DEPTH-1) begin : g_last
			assign right_s = '0;
			assign right_t = '0;
		end else begin : g_mid_r
			assign right_s = sym_w[i+1];
			assign right_t = tap_w[i+1];
		end
		lsr_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_sym  (left_s),
			.right_sym (right_s),
			.right_tap (right_t),
			.sym       (sym_w[i]),
			.tap       (tap_w[i])
		);
	end

	// ---------------------------------------------------------------- rules
	assign wk_plus = wk_q + LNW'(1);
	assign rslot   = (state_q == lsr_pkg::S_WRITE) ? wk_plus[RW-1:0] : '0;

	lsr_rule_mem #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.MAX_RULE_LEN  (MAX_RULE_LEN)
	) u_rule_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.busy      (mem_busy),
		.sym_we    (sym_we),
		.sym_wid   (rid_q[AW-1:0]),
		.sym_wslot (slot_q[RW-1:0]),
		.sym_wdata (symin_q),
		.sym_rid   (csym_q[AW-1:0]),
		.sym_rslot (rslot),
		.sym_rdata (rule_sym),
		.len_we    (len_we),
		.len_wid   (rid_q[AW-1:0]),
		.len_wdata (LNW'(len_q)),
		.len_rid   (csym_q[AW-1:0]),
		.len_rdata (rule_len)
	);

	// ---------------------------------------------------------------- control
	assign accept  = s_tvalid & s_tready;
	assign rid_ok  = (32'(rid_q) < ALPHABET_SIZE);
	assign slot_ok = (32'(slot_q) < MAX_RULE_LEN);
	assign len_ok  = (32'(len_q) <= MAX_RULE_LEN);

	// A symbol outside the alphabet rewrites to itself.
	assign in_alpha  = (32'(csym_q) < ALPHABET_SIZE);
	assign rep       = in_alpha ? rule_len : LNW'(1);
	assign rsym      = in_alpha ? rule_sym : csym_q;
	assign new_count = SW'(count_q) + SW'(rep) - SW'(1);
	assign cur_rep   = SW'(cursor_q) + SW'(rep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lsr_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		cursor_d = cursor_q;
		scan_d   = scan_q;
		wk_d     = wk_q;
		csym_d   = csym_q;
		rdsym_d  = rdsym_q;
		status_d = status_q;
		cmd      = '{op: lsr_pkg::CELL_HOLD, pos: '0, sym: '0};
		sym_we   = 1'b0;
		len_we   = 1'b0;
		load_out = 1'b0;
		s_tready = 1'b0;

		unique case (state_q)
			lsr_pkg::S_IDLE: begin
				s_tready = !mem_busy;
				if (s_tvalid && !mem_busy) state_d = lsr_pkg::S_EXEC;
			end
			lsr_pkg::S_EXEC: begin
				rdsym_d  = '0;
				status_d = lsr_pkg::STAT_DONE;
				state_d  = lsr_pkg::S_DONE;
				unique case (op_q)
					lsr_pkg::OP_STEP: begin
						if (count_q == '0) begin
							status_d = lsr_pkg::STAT_EMPTY;
						end else begin
							cmd.op  = lsr_pkg::CELL_TAP_LOAD;
							cmd.pos = lsr_pkg::POS_W'(cursor_q);
							scan_d  = cursor_q;
							state_d = lsr_pkg::S_SCAN;
						end
					end
					lsr_pkg::OP_RULE_SYM: begin
						if (rid_ok && slot_ok) sym_we = 1'b1;
						else status_d = lsr_pkg::STAT_RANGE;
					end
					lsr_pkg::OP_RULE_LEN: begin
						if (rid_ok && len_ok) len_we = 1'b1;
						else status_d = lsr_pkg::STAT_RANGE;
					end
					lsr_pkg::OP_RESTART: begin
						cmd.op   = lsr_pkg::CELL_PUT;
						cmd.pos  = '0;
						cmd.sym  = seed_q;
						count_d  = LW'(1);
						cursor_d = '0;
					end
					lsr_pkg::OP_READ: begin
						if (LW'(slot_q) < count_q && 32'(slot_q) < STRING_DEPTH) begin
							cmd.op  = lsr_pkg::CELL_TAP_LOAD;
							cmd.pos = lsr_pkg::POS_W'(slot_q);
							scan_d  = CW'(slot_q);
							state_d = lsr_pkg::S_SCAN;
						end else begin
							status_d = lsr_pkg::STAT_RANGE;
						end
					end
					default: status_d = lsr_pkg::STAT_RANGE;
				endcase
			end
			lsr_pkg::S_SCAN: begin
				if (scan_q == '0) begin
					csym_d = tap_w[0];
					if (op_q == lsr_pkg::OP_READ) begin
						rdsym_d = tap_w[0];
						state_d = lsr_pkg::S_DONE;
					end else begin
						state_d = lsr_pkg::S_FETCH;
					end
				end else begin
					cmd.op = lsr_pkg::CELL_TAP_SHIFT;
					scan_d = scan_q - CW'(1);
				end
			end
			lsr_pkg::S_FETCH: begin
				wk_d    = '0;
				state_d = lsr_pkg::S_WRITE;
			end
			lsr_pkg::S_WRITE: begin
				if (wk_q == '0 && new_count > SW'(STRING_DEPTH)) begin
					status_d = lsr_pkg::STAT_FULL;
					state_d  = lsr_pkg::S_DONE;
				end else if (rep == '0) begin
					// Deleting rule: the tail moves down over the cursor.
					cmd.op   = lsr_pkg::CELL_DELETE;
					cmd.pos  = lsr_pkg::POS_W'(cursor_q);
					count_d  = count_q - LW'(1);
					if (LW'(cursor_q) >= count_q - LW'(1)) cursor_d = '0;
					state_d  = lsr_pkg::S_DONE;
				end else begin
					cmd.op  = (wk_q == '0) ? lsr_pkg::CELL_PUT : lsr_pkg::CELL_INSERT;
					cmd.pos = lsr_pkg::POS_W'(cursor_q) + lsr_pkg::POS_W'(wk_q);
					cmd.sym = rsym;
					wk_d    = wk_plus;
					if (wk_q == rep - LNW'(1)) begin
						count_d  = LW'(new_count);
						cursor_d = (cur_rep >= new_count) ? '0 : CW'(cur_rep);
						state_d  = lsr_pkg::S_DONE;
					end
				end
			end
			lsr_pkg::S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = lsr_pkg::S_IDLE;
				end
			end
			default: state_d = lsr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= LW'(1);
			cursor_q   <= '0;
			scan_q     <= '0;
			wk_q       <= '0;
			csym_q     <= '0;
			rdsym_q    <= '0;
			status_q   <= lsr_pkg::STAT_DONE;
			seed_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
			scan_q   <= scan_d;
			wk_q     <= wk_d;
			csym_q   <= csym_d;
			rdsym_q  <= rdsym_d;
			status_q <= status_d;
			if (cfg_wr) seed_q <= pwdata[SYM_W-1:0];
			if (load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser;
			rid_q   <= s_tdata[6:0];
			slot_q  <= s_tdata[14:7];
			symin_q <= s_tdata[21:15];
			len_q   <= s_tdata[26:22];
		end
		if (load_out) begin
			m_tdata_q <= {rdsym_q, lsr_pkg::CUR_W'(cursor_q), lsr_pkg::SLEN_W'(count_q)};
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// ---------------------------------------------------------------- apb
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(seed_q);

	// ---------------------------------------------------------------- checks
	`LSR_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_q) <= STRING_DEPTH, "string count too large")
	`LSR_ASSERT_NOW(a_cursor_in, count_q != '0, LW'(cursor_q) < count_q, "cursor past end")
	`LSR_ASSERT_NEXT(a_accept_exec, accept, state_q == lsr_pkg::S_EXEC, "item not executed")
	`LSR_ASSERT_NOW(a_wk_bound, state_q == lsr_pkg::S_WRITE, 32'(wk_q) < MAX_RULE_LEN, "rule index")

endmodule
